@@ hw/rtl/ncs_pkg.sv @@
// shared types and constants of the nested loop command sequencer
package ncs_pkg;

    localparam int PTR_W  = 9;    // read pointer and program length width
    localparam int CNT_W  = 16;
    localparam int CODE_W = 16;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 32;

    localparam logic [CODE_W-1:0] CODE_OPEN  = 16'hFFFE;
    localparam logic [CODE_W-1:0] CODE_CLOSE = 16'hFFFF;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_STEP    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [1:0] FAULT_NONE     = 2'd0;
    localparam logic [1:0] FAULT_OVERFLOW = 2'd1;
    localparam logic [1:0] FAULT_UNMATCH  = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;      // write one program entry
        logic restart;   // rewind pointer, depth, repeats, fault
        logic fetch;     // read program entry and top of stack
        logic exec;      // commit one interpreter action and emit result
    } ncs_cmd_t;

endpackage

@@ hw/rtl/ncs_ctrl.sv @@
// controller state machine of the sequencer
module ncs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic [1:0]        s_tuser,
    input  logic              out_free,
    output logic              s_tready,
    output ncs_pkg::ncs_cmd_t cmd
);
    import ncs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_tuser)
                        OP_LOAD:    cmd.load = 1'b1;
                        OP_RESTART: cmd.restart = 1'b1;
                        OP_STEP: begin
                            cmd.fetch  = 1'b1;
                            state_next = ST_EXEC;
                        end
                        default: ;
                    endcase
                end
            end
            ST_EXEC: begin
                // wait here while the previous result is still held
                if (out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hw/rtl/ncs_datapath.sv @@
// program store, loop stack and interpreter state of the sequencer
module ncs_datapath #(
    parameter int PROGRAM_DEPTH = 256,
    parameter int NEST_DEPTH    = 256
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ncs_pkg::ncs_cmd_t            cmd,
    input  logic                         cfg_wen,
    input  logic [ncs_pkg::PTR_W-1:0]    cfg_wdata,
    input  logic [7:0]                   entry_address,
    input  logic [ncs_pkg::CNT_W-1:0]    entry_count,
    input  logic [ncs_pkg::CODE_W-1:0]   entry_code,
    output logic [ncs_pkg::M_DATA_W-1:0] res_data
);
    import ncs_pkg::*;

    localparam int PA_W  = $clog2(PROGRAM_DEPTH);
    localparam int SA_W  = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam int D_W   = $clog2(NEST_DEPTH + 1);
    localparam int STK_W = CNT_W + PTR_W;

    logic [CNT_W+CODE_W-1:0] prog_mem [PROGRAM_DEPTH];
    logic [STK_W-1:0]        stk_mem  [NEST_DEPTH];

    logic [CNT_W+CODE_W-1:0] prog_q_reg;
    logic [STK_W-1:0]        stk_q_reg;
    logic [PTR_W-1:0]        len_reg;
    logic [PTR_W-1:0]        ptr_reg, ptr_next;
    logic [D_W-1:0]          depth_reg, depth_next;
    logic [CNT_W-1:0]        rep_reg, rep_next;
    logic [1:0]              fault_reg, fault_next;

    logic [PTR_W-1:0]  eff_len;
    logic [CNT_W-1:0]  e_count, s_count;
    logic [CODE_W-1:0] e_code;
    logic [PTR_W-1:0]  s_start;
    logic              stk_we;
    logic [SA_W-1:0]   stk_waddr;
    logic [STK_W-1:0]  stk_wdata;
    logic              emit;

    assign eff_len = (32'(len_reg) > PROGRAM_DEPTH) ? PTR_W'(PROGRAM_DEPTH) : len_reg;
    assign e_count = prog_q_reg[CNT_W+CODE_W-1:CODE_W];
    assign e_code  = prog_q_reg[CODE_W-1:0];
    assign s_count = stk_q_reg[STK_W-1:PTR_W];
    assign s_start = stk_q_reg[PTR_W-1:0];

    // one interpreter action on the fetched entry
    always_comb begin
        ptr_next   = ptr_reg;
        depth_next = depth_reg;
        rep_next   = rep_reg;
        fault_next = fault_reg;
        stk_we     = 1'b0;
        stk_waddr  = SA_W'(depth_reg);
        stk_wdata  = {e_count, ptr_reg};
        emit       = 1'b0;
        if (fault_reg == FAULT_NONE && ptr_reg < eff_len) begin
            if (e_code == CODE_OPEN) begin
                if (32'(depth_reg) >= NEST_DEPTH) begin
                    fault_next = FAULT_OVERFLOW;
                end else begin
                    stk_we     = 1'b1;
                    depth_next = D_W'(depth_reg + 1'b1);
                    ptr_next   = PTR_W'(ptr_reg + 1'b1);
                end
            end else if (e_code == CODE_CLOSE) begin
                stk_waddr = SA_W'(depth_reg - 1'b1);
                stk_wdata = {CNT_W'(s_count - 1'b1), s_start};
                if (depth_reg == '0) begin
                    fault_next = FAULT_UNMATCH;
                end else if (s_count == '0) begin
                    ptr_next = PTR_W'(s_start + 1'b1);
                end else if (s_count > CNT_W'(1)) begin
                    stk_we   = 1'b1;
                    ptr_next = PTR_W'(s_start + 1'b1);
                end else begin
                    depth_next = D_W'(depth_reg - 1'b1);
                    ptr_next   = PTR_W'(ptr_reg + 1'b1);
                end
            end else if (e_count == '0) begin
                ptr_next = PTR_W'(ptr_reg + 1'b1);
            end else begin
                emit = 1'b1;
                if ({1'b0, rep_reg} + 17'd1 >= {1'b0, e_count}) begin
                    rep_next = '0;
                    ptr_next = PTR_W'(ptr_reg + 1'b1);
                end else begin
                    rep_next = CNT_W'(rep_reg + 1'b1);
                end
            end
        end
    end

    // fields from the lowest bit up: op_valid, op_code, finished, fault, nest_depth
    assign res_data = {3'b000, 9'(depth_next), fault_next, (ptr_next >= eff_len),
                       (emit ? e_code : CODE_W'(0)), emit};

    // program store
    always_ff @(posedge aclk) begin
        if (cmd.load && 32'(entry_address) < PROGRAM_DEPTH) begin
            prog_mem[PA_W'(entry_address)] <= {entry_count, entry_code};
        end
        if (cmd.fetch) begin
            prog_q_reg <= prog_mem[PA_W'(ptr_reg)];
        end
    end

    // loop stack, count and start position per level
    always_ff @(posedge aclk) begin
        if (cmd.exec && stk_we) begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        if (cmd.fetch) begin
            stk_q_reg <= stk_mem[SA_W'(depth_reg - 1'b1)];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            ptr_reg   <= '0;
            depth_reg <= '0;
            rep_reg   <= '0;
            fault_reg <= FAULT_NONE;
        end else begin
            if (cfg_wen) begin
                len_reg <= cfg_wdata;
            end
            if (cmd.restart) begin
                ptr_reg   <= '0;
                depth_reg <= '0;
                rep_reg   <= '0;
                fault_reg <= FAULT_NONE;
            end else if (cmd.exec) begin
                ptr_reg   <= ptr_next;
                depth_reg <= depth_next;
                rep_reg   <= rep_next;
                fault_reg <= fault_next;
            end
        end
    end

endmodule

@@ hw/rtl/ncs_out_reg.sv @@
// output register of the result channel
module ncs_out_reg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         load,
    input  logic [ncs_pkg::M_DATA_W-1:0] data_in,
    input  logic                         m_tready,
    output logic                         m_tvalid,
    output logic [ncs_pkg::M_DATA_W-1:0] m_tdata,
    output logic                         out_free
);
    import ncs_pkg::*;

    logic                valid_reg;
    logic [M_DATA_W-1:0] data_reg;

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign out_free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_in;
        end
    end

endmodule

@@ hw/rtl/nested_loop_command_sequencer.sv @@
// top level of the nested loop command sequencer
//
// runs a program of (count, code) entries held in an on-chip store: code 0xfffe opens a
// loop repeated count times (0 repeats forever), 0xffff closes the innermost loop, any
// other code is an operation emitted count times. a load beat (tuser 0) writes one entry;
// a restart beat (tuser 2) rewinds pointer, loop depth, repeat counter and fault; a step
// beat (tuser 1) performs one interpreter action and gives one result beat. a step first
// reads the program store and the top of the loop stack (both memories have registered
// read data), then updates the pointer and stack and loads the result register. the step
// is held before that update while an earlier result is still waiting on the master side.
// tuser 3 is dropped. loop overflow and an unmatched close latch a fault that freezes the
// program until a restart. the user must write program_length through cfg_wen/cfg_wdata
// only while the block is idle, which the block does not enforce; the stores need no
// clearing after reset; a step must never read an entry never loaded.
module nested_loop_command_sequencer #(
    parameter int PROGRAM_DEPTH = 256,   // entries in the program store
    parameter int NEST_DEPTH    = 256    // levels in the loop stack
) (
    input  logic         aclk,
    input  logic         aresetn,
    // program length register
    input  logic         cfg_wen,
    input  logic [8:0]   cfg_wdata,
    // command beats
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,    // entry_address[7:0], entry_count[23:8], entry_code[39:24]
    input  logic [1:0]   s_tuser,    // operation[1:0]
    // result beats
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata     // op_valid[0], op_code[16:1], finished[17],
                                     // fault[19:18], nest_depth[28:20], zero[31:29]
);
    import ncs_pkg::*;

    ncs_cmd_t            cmd;
    logic                out_free;
    logic [M_DATA_W-1:0] res_data;

    // sequencing of load, restart and the fetch and execute phases of a step
    ncs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .out_free (out_free),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    // program store, loop stack and interpreter registers
    ncs_datapath #(
        .PROGRAM_DEPTH (PROGRAM_DEPTH),
        .NEST_DEPTH    (NEST_DEPTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .entry_address (s_tdata[7:0]),
        .entry_count   (s_tdata[23:8]),
        .entry_code    (s_tdata[39:24]),
        .res_data      (res_data)
    );

    // result register decouples the master side
    ncs_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (cmd.exec),
        .data_in  (res_data),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .out_free (out_free)
    );

`ifndef ASSERT_OFF
    // a committed step always shows its result beat next cycle
    a_exec_gives_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> m_tvalid)
        else $error("step result not presented");

    // no new beat is taken while a step is in flight
    a_busy_after_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fetch |=> !s_tready)
        else $error("beat accepted during a step");

    // reported depth never exceeds the stack size
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> 32'(m_tdata[28:20]) <= NEST_DEPTH)
        else $error("nest depth out of range");

    // a frozen program emits no operation
    a_fault_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[19:18] != FAULT_NONE) |-> !m_tdata[0])
        else $error("operation emitted with fault set");
`endif

endmodule
